[hdl/assert_macros.svh]
// assertion macros shared by the deque manager rtl
// expects signals clk and rst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[hdl/lldq_pkg.sv]
// package for the linked-list deque manager: sizes, opcodes, status codes, fsm states
// no dependencies
package lldq_pkg;

    localparam int NODE_COUNT = 64;
    localparam int HANDLE_W   = $clog2(NODE_COUNT);
    localparam int COUNT_W    = $clog2(NODE_COUNT + 1);
    localparam int PAYLOAD_W  = 32;
    localparam int OP_W       = 3;
    localparam int STATUS_W   = 2;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FIRST  = 3'd0,
        OP_INS_LAST   = 3'd1,
        OP_REM_HANDLE = 3'd2,
        OP_REM_FIRST  = 3'd3,
        OP_REM_LAST   = 3'd4,
        OP_PEEK_FIRST = 3'd5,
        OP_PEEK_LAST  = 3'd6
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 2'd0,
        ST_EMPTY      = 2'd1,
        ST_FULL       = 2'd2,
        ST_BAD_HANDLE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LINK,
        S_HOLD
    } state_t;

endpackage

[hdl/lldq_ram.sv]
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module lldq_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hdl/linked_list_deque_manager.sv]
// linked-list deque manager: node pool in next/prev/payload rams, free list, fsm
// depends on lldq_pkg, lldq_ram and assert_macros.svh
//
//   channel  handshake              fields
//   req      req_valid/req_ready    opcode, payload_in, node_handle
//   rsp      rsp_valid/rsp_ready    payload_out, handle_out, status, count_out
//
// a transaction goes through accept with ram read, execute with first link
// writes, second link write with the response loaded into the output register.
// the link step is separate because insert and remove write one link ram twice.
// req_ready is high in the idle state; a response waiting on rsp_ready holds
// the block after its writes are done. no clearing pass after reset.
`include "assert_macros.svh"

module linked_list_deque_manager (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  logic [lldq_pkg::OP_W-1:0]      opcode,
    input  logic [lldq_pkg::PAYLOAD_W-1:0] payload_in,
    input  logic [lldq_pkg::HANDLE_W-1:0]  node_handle,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output logic [lldq_pkg::PAYLOAD_W-1:0] payload_out,
    output logic [lldq_pkg::HANDLE_W-1:0]  handle_out,
    output logic [lldq_pkg::STATUS_W-1:0]  status,
    output logic [lldq_pkg::COUNT_W-1:0]   count_out
);

    import lldq_pkg::*;

    state_t                state_reg, state_next;
    logic [HANDLE_W-1:0]   first_reg, first_next;
    logic [HANDLE_W-1:0]   last_reg, last_next;
    logic [HANDLE_W-1:0]   free_head_reg, free_head_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [COUNT_W-1:0]    freed_reg, freed_next;
    logic [COUNT_W-1:0]    fresh_reg, fresh_next;
    logic [NODE_COUNT-1:0] in_list_reg, in_list_next;

    op_t                   op_reg, op_next;
    logic [PAYLOAD_W-1:0]  data_reg, data_next;
    logic [HANDLE_W-1:0]   node_reg, node_next;
    status_t               st_reg, st_next;
    logic                  act_reg, act_next;
    logic                  use_free_reg, use_free_next;
    logic [PAYLOAD_W-1:0]  res_pay_reg, res_pay_next;
    logic [HANDLE_W-1:0]   res_hdl_reg, res_hdl_next;
    logic [COUNT_W-1:0]    res_cnt_reg, res_cnt_next;

    logic                  rsp_valid_reg, rsp_valid_next;
    logic [PAYLOAD_W-1:0]  pay_out_reg, pay_out_next;
    logic [HANDLE_W-1:0]   hdl_out_reg, hdl_out_next;
    logic [STATUS_W-1:0]   st_out_reg, st_out_next;
    logic [COUNT_W-1:0]    cnt_out_reg, cnt_out_next;

    logic                  accept;
    logic [HANDLE_W-1:0]   dec_node;
    status_t               dec_st;
    logic                  dec_act;
    logic                  dec_use_free;
    logic                  list_empty;
    logic                  full_rsp;

    logic                  nl_we, pl_we, pd_we;
    logic [HANDLE_W-1:0]   nl_waddr, pl_waddr;
    logic [HANDLE_W-1:0]   nl_wdata, pl_wdata;
    logic [HANDLE_W-1:0]   nl_rdata, pl_rdata;
    logic [PAYLOAD_W-1:0]  pd_rdata;

    lldq_ram #(.DEPTH(NODE_COUNT), .WIDTH(HANDLE_W)) u_next_ram (
        .clk     (clk),
        .wr_en   (nl_we),
        .wr_addr (nl_waddr),
        .wr_data (nl_wdata),
        .rd_en   (accept),
        .rd_addr (dec_node),
        .rd_data (nl_rdata)
    );

    lldq_ram #(.DEPTH(NODE_COUNT), .WIDTH(HANDLE_W)) u_prev_ram (
        .clk     (clk),
        .wr_en   (pl_we),
        .wr_addr (pl_waddr),
        .wr_data (pl_wdata),
        .rd_en   (accept),
        .rd_addr (dec_node),
        .rd_data (pl_rdata)
    );

    lldq_ram #(.DEPTH(NODE_COUNT), .WIDTH(PAYLOAD_W)) u_payload_ram (
        .clk     (clk),
        .wr_en   (pd_we),
        .wr_addr (node_reg),
        .wr_data (data_reg),
        .rd_en   (accept),
        .rd_addr (dec_node),
        .rd_data (pd_rdata)
    );

    assign req_ready   = (state_reg == S_IDLE);
    assign accept      = req_valid && req_ready;
    assign list_empty  = (count_reg == '0);
    assign full_rsp    = rsp_valid_reg && (st_out_reg == ST_FULL);
    assign rsp_valid   = rsp_valid_reg;
    assign payload_out = pay_out_reg;
    assign handle_out  = hdl_out_reg;
    assign status      = st_out_reg;
    assign count_out   = cnt_out_reg;

    // request decode against the current list state
    always_comb
    begin
        dec_node     = node_handle;
        dec_st       = ST_OK;
        dec_act      = 1'b0;
        dec_use_free = 1'b0;
        case (op_t'(opcode))
            OP_INS_FIRST, OP_INS_LAST:
            begin
                if (freed_reg != '0)
                begin
                    dec_node     = free_head_reg;
                    dec_use_free = 1'b1;
                    dec_act      = 1'b1;
                end
                else if (fresh_reg < COUNT_W'(NODE_COUNT))
                begin
                    dec_node = fresh_reg[HANDLE_W-1:0];
                    dec_act  = 1'b1;
                end
                else
                begin
                    dec_st = ST_FULL;
                end
            end
            OP_REM_HANDLE:
            begin
                if (list_empty)
                begin
                    dec_st = ST_EMPTY;
                end
                else if (!in_list_reg[node_handle])
                begin
                    dec_st = ST_BAD_HANDLE;
                end
                else
                begin
                    dec_act = 1'b1;
                end
            end
            OP_REM_FIRST, OP_PEEK_FIRST:
            begin
                dec_node = first_reg;
                if (list_empty)
                begin
                    dec_st = ST_EMPTY;
                end
                else
                begin
                    dec_act = 1'b1;
                end
            end
            OP_REM_LAST, OP_PEEK_LAST:
            begin
                dec_node = last_reg;
                if (list_empty)
                begin
                    dec_st = ST_EMPTY;
                end
                else
                begin
                    dec_act = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        free_head_next = free_head_reg;
        count_next     = count_reg;
        freed_next     = freed_reg;
        fresh_next     = fresh_reg;
        in_list_next   = in_list_reg;
        op_next        = op_reg;
        data_next      = data_reg;
        node_next      = node_reg;
        st_next        = st_reg;
        act_next       = act_reg;
        use_free_next  = use_free_reg;
        res_pay_next   = res_pay_reg;
        res_hdl_next   = res_hdl_reg;
        res_cnt_next   = res_cnt_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        pay_out_next   = pay_out_reg;
        hdl_out_next   = hdl_out_reg;
        st_out_next    = st_out_reg;
        cnt_out_next   = cnt_out_reg;
        nl_we          = 1'b0;
        nl_waddr       = node_reg;
        nl_wdata       = '0;
        pl_we          = 1'b0;
        pl_waddr       = node_reg;
        pl_wdata       = '0;
        pd_we          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next       = op_t'(opcode);
                    data_next     = payload_in;
                    node_next     = dec_node;
                    st_next       = dec_st;
                    act_next      = dec_act;
                    use_free_next = dec_use_free;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_pay_next = '0;
                res_hdl_next = '0;
                if (act_reg)
                begin
                    case (op_reg)
                        OP_INS_FIRST, OP_INS_LAST:
                        begin
                            pd_we                  = 1'b1;
                            in_list_next[node_reg] = 1'b1;
                            count_next             = count_reg + COUNT_W'(1);
                            res_hdl_next           = node_reg;
                            if (use_free_reg)
                            begin
                                free_head_next = nl_rdata;
                                freed_next     = freed_reg - COUNT_W'(1);
                            end
                            else
                            begin
                                fresh_next = fresh_reg + COUNT_W'(1);
                            end
                            if (list_empty)
                            begin
                                nl_we      = 1'b1;
                                pl_we      = 1'b1;
                                first_next = node_reg;
                                last_next  = node_reg;
                            end
                            else if (op_reg == OP_INS_FIRST)
                            begin
                                nl_we      = 1'b1;
                                nl_wdata   = first_reg;
                                pl_we      = 1'b1;
                                pl_waddr   = first_reg;
                                pl_wdata   = node_reg;
                                first_next = node_reg;
                            end
                            else
                            begin
                                pl_we     = 1'b1;
                                pl_wdata  = last_reg;
                                nl_we     = 1'b1;
                                nl_waddr  = last_reg;
                                nl_wdata  = node_reg;
                                last_next = node_reg;
                            end
                        end
                        OP_REM_HANDLE, OP_REM_FIRST, OP_REM_LAST:
                        begin
                            // unlink: neighbors take over each other's links
                            if (node_reg == first_reg)
                            begin
                                first_next = nl_rdata;
                            end
                            else
                            begin
                                nl_we    = 1'b1;
                                nl_waddr = pl_rdata;
                                nl_wdata = nl_rdata;
                            end
                            if (node_reg == last_reg)
                            begin
                                last_next = pl_rdata;
                            end
                            else
                            begin
                                pl_we    = 1'b1;
                                pl_waddr = nl_rdata;
                                pl_wdata = pl_rdata;
                            end
                            count_next = count_reg - COUNT_W'(1);
                            if (count_reg == COUNT_W'(1))
                            begin
                                first_next = '0;
                                last_next  = '0;
                            end
                            in_list_next[node_reg] = 1'b0;
                            res_pay_next           = pd_rdata;
                            res_hdl_next           = node_reg;
                        end
                        OP_PEEK_FIRST, OP_PEEK_LAST:
                        begin
                            res_pay_next = pd_rdata;
                            res_hdl_next = node_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                res_cnt_next = count_next;
                state_next   = S_LINK;
            end
            S_LINK:
            begin
                if (act_reg)
                begin
                    case (op_reg)
                        OP_INS_FIRST:
                        begin
                            pl_we = 1'b1;
                        end
                        OP_INS_LAST:
                        begin
                            nl_we = 1'b1;
                        end
                        OP_REM_HANDLE, OP_REM_FIRST, OP_REM_LAST:
                        begin
                            // push the freed node onto the free list
                            nl_we          = 1'b1;
                            nl_wdata       = free_head_reg;
                            free_head_next = node_reg;
                            freed_next     = freed_reg + COUNT_W'(1);
                        end
                        default:
                        begin
                        end
                    endcase
                end
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    pay_out_next   = res_pay_reg;
                    hdl_out_next   = res_hdl_reg;
                    st_out_next    = st_reg;
                    cnt_out_next   = res_cnt_reg;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next = 1'b1;
                    pay_out_next   = res_pay_reg;
                    hdl_out_next   = res_hdl_reg;
                    st_out_next    = st_reg;
                    cnt_out_next   = res_cnt_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            first_reg     <= '0;
            last_reg      <= '0;
            free_head_reg <= '0;
            count_reg     <= '0;
            freed_reg     <= '0;
            fresh_reg     <= '0;
            in_list_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            last_reg      <= last_next;
            free_head_reg <= free_head_next;
            count_reg     <= count_next;
            freed_reg     <= freed_next;
            fresh_reg     <= fresh_next;
            in_list_reg   <= in_list_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        data_reg     <= data_next;
        node_reg     <= node_next;
        st_reg       <= st_next;
        act_reg      <= act_next;
        use_free_reg <= use_free_next;
        res_pay_reg  <= res_pay_next;
        res_hdl_reg  <= res_hdl_next;
        res_cnt_reg  <= res_cnt_next;
        pay_out_reg  <= pay_out_next;
        hdl_out_reg  <= hdl_out_next;
        st_out_reg   <= st_out_next;
        cnt_out_reg  <= cnt_out_next;
    end

    `ASSERT_ALWAYS(a_count_range, count_reg <= COUNT_W'(NODE_COUNT), "entry count above pool size")
    `ASSERT_ALWAYS(a_in_list_count, $countones(in_list_reg) == count_reg, "membership count wrong")
    `ASSERT_IMPLIES(a_pool_balance, req_ready, count_reg + freed_reg == fresh_reg, "lost a node")
    `ASSERT_IMPLIES(a_empty_ends, list_empty, first_reg == '0 && last_reg == '0, "stale list ends")
    `ASSERT_IMPLIES(a_full_count, full_rsp, cnt_out_reg == COUNT_W'(NODE_COUNT), "full too early")

endmodule

[bench/tb.sv]
// testbench for linked_list_deque_manager: directed and random deque traffic
// checked against a transaction-level predictor of the node pool and free list
// depends on lldq_pkg and the linked_list_deque_manager rtl
module tb;
    import lldq_pkg::*;

    localparam int CYCLE_LIMIT = 800000;

    typedef struct packed {
        logic [PAYLOAD_W-1:0] payload;
        logic [HANDLE_W-1:0]  handle;
        status_t              st;
        logic [COUNT_W-1:0]   count;
    } rsp_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    logic [OP_W-1:0]      opcode = '0;
    logic [PAYLOAD_W-1:0] payload_in = '0;
    logic [HANDLE_W-1:0]  node_handle = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    logic [PAYLOAD_W-1:0] payload_out;
    logic [HANDLE_W-1:0]  handle_out;
    logic [STATUS_W-1:0]  status;
    logic [COUNT_W-1:0]   count_out;

    // predictor copy of the node pool
    bit [HANDLE_W-1:0]  link_next [NODE_COUNT];
    bit [HANDLE_W-1:0]  link_prev [NODE_COUNT];
    bit [PAYLOAD_W-1:0] node_data [NODE_COUNT];
    bit                 node_listed [NODE_COUNT];
    bit [HANDLE_W-1:0]  head_idx;
    bit [HANDLE_W-1:0]  tail_idx;
    bit [COUNT_W-1:0]   live_cnt;
    bit [HANDLE_W-1:0]  free_top;
    bit [COUNT_W-1:0]   free_cnt;
    bit [COUNT_W-1:0]   fresh_cnt;

    rsp_t rsp_expected [$];
    int   fail_cnt = 0;
    int   rsp_stall_left = 0;
    int   cycle_cnt = 0;
    bit   no_idle = 1'b0;

    linked_list_deque_manager dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .opcode      (opcode),
        .payload_in  (payload_in),
        .node_handle (node_handle),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .payload_out (payload_out),
        .handle_out  (handle_out),
        .status      (status),
        .count_out   (count_out)
    );

    always #5 clk = ~clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic bit [PAYLOAD_W-1:0] unlink_node(input bit [HANDLE_W-1:0] h);
        bit [HANDLE_W-1:0]  p;
        bit [HANDLE_W-1:0]  nx;
        bit [PAYLOAD_W-1:0] data;
        p = link_prev[h];
        nx = link_next[h];
        data = node_data[h];
        if (h == head_idx)
            head_idx = nx;
        else
            link_next[p] = nx;
        if (h == tail_idx)
            tail_idx = p;
        else
            link_prev[nx] = p;
        live_cnt--;
        if (live_cnt == 0)
        begin
            head_idx = '0;
            tail_idx = '0;
        end
        node_listed[h] = 1'b0;
        link_next[h] = free_top;
        free_top = h;
        free_cnt++;
        return data;
    endfunction

    task automatic predict_response(input op_t op, input logic [PAYLOAD_W-1:0] data,
                                    input logic [HANDLE_W-1:0] hdl);
        rsp_t              r;
        bit [HANDLE_W-1:0] n;
        r = '{payload: '0, handle: '0, st: ST_OK, count: '0};
        case (op)
            OP_INS_FIRST, OP_INS_LAST:
            begin
                if (free_cnt == 0 && fresh_cnt == NODE_COUNT)
                    r.st = ST_FULL;
                else
                begin
                    if (free_cnt != 0)
                    begin
                        n = free_top;
                        free_top = link_next[n];
                        free_cnt--;
                    end
                    else
                    begin
                        n = fresh_cnt[HANDLE_W-1:0];
                        fresh_cnt++;
                    end
                    node_data[n] = data;
                    node_listed[n] = 1'b1;
                    if (live_cnt == 0)
                    begin
                        link_next[n] = '0;
                        link_prev[n] = '0;
                        head_idx = n;
                        tail_idx = n;
                    end
                    else if (op == OP_INS_FIRST)
                    begin
                        link_next[n] = head_idx;
                        link_prev[n] = '0;
                        link_prev[head_idx] = n;
                        head_idx = n;
                    end
                    else
                    begin
                        link_prev[n] = tail_idx;
                        link_next[n] = '0;
                        link_next[tail_idx] = n;
                        tail_idx = n;
                    end
                    live_cnt++;
                    r.handle = n;
                end
            end
            OP_REM_HANDLE:
            begin
                if (live_cnt == 0)
                    r.st = ST_EMPTY;
                else if (!node_listed[hdl])
                    r.st = ST_BAD_HANDLE;
                else
                begin
                    r.payload = unlink_node(hdl);
                    r.handle = hdl;
                end
            end
            OP_REM_FIRST, OP_REM_LAST:
            begin
                if (live_cnt == 0)
                    r.st = ST_EMPTY;
                else
                begin
                    n = (op == OP_REM_FIRST) ? head_idx : tail_idx;
                    r.payload = unlink_node(n);
                    r.handle = n;
                end
            end
            OP_PEEK_FIRST, OP_PEEK_LAST:
            begin
                if (live_cnt == 0)
                    r.st = ST_EMPTY;
                else
                begin
                    n = (op == OP_PEEK_FIRST) ? head_idx : tail_idx;
                    r.payload = node_data[n];
                    r.handle = n;
                end
            end
            default:
            begin
            end
        endcase
        r.count = live_cnt;
        rsp_expected.push_back(r);
    endtask

    // handle of some node in the list, or any handle when the list is empty
    function automatic logic [HANDLE_W-1:0] pick_listed();
        int start;
        int idx;
        start = $urandom_range(0, NODE_COUNT - 1);
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            idx = (start + i) % NODE_COUNT;
            if (node_listed[idx])
                return idx[HANDLE_W-1:0];
        end
        return start[HANDLE_W-1:0];
    endfunction

    task automatic req_gap(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    task automatic send_req(input op_t op, input logic [PAYLOAD_W-1:0] data,
                            input logic [HANDLE_W-1:0] hdl);
        @(negedge clk);
        opcode <= op;
        payload_in <= data;
        node_handle <= hdl;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        predict_response(op, data, hdl);
        if (!no_idle && $urandom_range(0, 1) == 1)
            req_gap(gap_len());
    endtask

    task automatic drain_responses();
        req_gap(1);
        wait (rsp_expected.size() == 0);
    endtask

    task automatic check_response();
        rsp_t want;
        if (rsp_expected.size() == 0)
        begin
            $display("%0t: unexpected response, actual payload %h handle %0d status %0d count %0d",
                     $time, payload_out, handle_out, status, count_out);
            fail_cnt++;
        end
        else
        begin
            want = rsp_expected.pop_front();
            if (payload_out !== want.payload)
            begin
                $display("%0t: payload_out mismatch, expected %h actual %h",
                         $time, want.payload, payload_out);
                fail_cnt++;
            end
            if (handle_out !== want.handle)
            begin
                $display("%0t: handle_out mismatch, expected %0d actual %0d",
                         $time, want.handle, handle_out);
                fail_cnt++;
            end
            if (status !== want.st)
            begin
                $display("%0t: status mismatch, expected %s actual %0d",
                         $time, want.st.name(), status);
                fail_cnt++;
            end
            if (count_out !== want.count)
            begin
                $display("%0t: count_out mismatch, expected %0d actual %0d",
                         $time, want.count, count_out);
                fail_cnt++;
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
            check_response();
    end

    // response side back-pressure
    always @(negedge clk)
    begin
        if (no_idle)
        begin
            rsp_stall_left = 0;
            rsp_ready <= 1'b1;
        end
        else if (rsp_stall_left > 0)
        begin
            rsp_stall_left--;
            rsp_ready <= 1'b0;
        end
        else if ($urandom_range(0, 3) != 0)
            rsp_ready <= 1'b1;
        else
        begin
            rsp_stall_left = gap_len() - 1;
            rsp_ready <= 1'b0;
        end
    end

    task automatic test_empty_list();
        send_req(OP_REM_FIRST, 32'h0000_0000, 6'd0);
        send_req(OP_REM_LAST, 32'hFFFF_FFFF, 6'd63);
        send_req(OP_PEEK_FIRST, 32'h0000_0000, 6'd0);
        send_req(OP_PEEK_LAST, 32'h0000_0000, 6'd0);
        send_req(OP_REM_HANDLE, 32'h0000_0000, 6'd0);
        send_req(OP_REM_HANDLE, 32'h0000_0000, 6'd63);
    endtask

    task automatic test_ends_and_handles();
        send_req(OP_INS_LAST, 32'h0000_0000, 6'd0);
        send_req(OP_INS_FIRST, 32'hFFFF_FFFF, 6'd63);
        send_req(OP_INS_LAST, 32'hA5A5_A5A5, 6'd0);
        send_req(OP_INS_FIRST, 32'h5A5A_5A5A, 6'd0);
        send_req(OP_PEEK_FIRST, 32'h0000_0000, 6'd0);
        send_req(OP_PEEK_LAST, 32'h0000_0000, 6'd0);
        // middle node, then the same handle again once it is free
        send_req(OP_REM_HANDLE, 32'h0000_0000, 6'd0);
        send_req(OP_REM_HANDLE, 32'h0000_0000, 6'd0);
        send_req(OP_REM_HANDLE, 32'h0000_0000, 6'd63);
        send_req(OP_REM_HANDLE, 32'h0000_0000, head_idx);
        send_req(OP_REM_HANDLE, 32'h0000_0000, tail_idx);
        send_req(OP_REM_FIRST, 32'h0000_0000, 6'd0);
        send_req(OP_PEEK_LAST, 32'h0000_0000, 6'd0);
        send_req(OP_INS_FIRST, 32'h1234_5678, 6'd0);
        send_req(OP_REM_LAST, 32'h0000_0000, 6'd0);
    endtask

    task automatic test_pool_full();
        op_t op;
        while (live_cnt < NODE_COUNT)
        begin
            if ($urandom_range(0, 1) == 1)
                op = OP_INS_LAST;
            else
                op = OP_INS_FIRST;
            send_req(op, $urandom, $urandom_range(0, NODE_COUNT - 1));
        end
        send_req(OP_INS_FIRST, $urandom, 6'd0);
        send_req(OP_INS_LAST, $urandom, 6'd63);
        send_req(OP_REM_HANDLE, 32'h0000_0000, pick_listed());
        send_req(OP_INS_LAST, $urandom, 6'd0);
        send_req(OP_INS_FIRST, $urandom, 6'd0);
        while (live_cnt > 0)
        begin
            case ($urandom_range(0, 2))
                0: op = OP_REM_FIRST;
                1: op = OP_REM_LAST;
                default: op = OP_REM_HANDLE;
            endcase
            send_req(op, $urandom, pick_listed());
        end
        send_req(OP_REM_FIRST, 32'h0000_0000, 6'd0);
    endtask

    // ins_weight: percent of transactions that insert
    task automatic test_random_mix(input int n_items, input int ins_weight);
        op_t                 op;
        logic [HANDLE_W-1:0] hdl;
        int                  r;
        for (int i = 0; i < n_items; i++)
        begin
            hdl = $urandom_range(0, NODE_COUNT - 1);
            if ($urandom_range(0, 99) < ins_weight)
            begin
                if ($urandom_range(0, 1) == 1)
                    op = OP_INS_LAST;
                else
                    op = OP_INS_FIRST;
            end
            else
            begin
                r = $urandom_range(0, 9);
                if (r < 4)
                begin
                    op = OP_REM_HANDLE;
                    if ($urandom_range(0, 9) != 0)
                        hdl = pick_listed();
                end
                else if (r == 4)
                    op = OP_REM_FIRST;
                else if (r < 7)
                    op = OP_REM_LAST;
                else if (r == 7)
                    op = OP_PEEK_FIRST;
                else
                    op = OP_PEEK_LAST;
            end
            send_req(op, $urandom, hdl);
        end
    endtask

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_list();
        test_ends_and_handles();
        test_pool_full();
        drain_responses();
        test_random_mix(250, 45);
        test_random_mix(250, 60);
        drain_responses();
        test_random_mix(250, 30);
        no_idle = 1'b1;
        test_random_mix(150, 50);
        no_idle = 1'b0;
        test_random_mix(250, 50);

        req_gap(1);
        wait (rsp_expected.size() == 0);
        repeat (20) @(posedge clk);
        if (fail_cnt == 0 && rsp_expected.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
